[rtl/lrr_pkg.sv]
// Shared types and constants for the LCG range generator.
// No dependencies; every other file in this block imports it.
package lrr_pkg;

  localparam int DATA_W    = 32;
  localparam int EXP_W     = 6;
  localparam int STAT_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DEN_W     = DATA_W + 1;
  localparam int QCNT_W    = 5;

  localparam logic [DATA_W-1:0] MULT_RST = 32'd1103515245;
  localparam logic [DATA_W-1:0] INC_RST  = 32'd12345;
  localparam logic [EXP_W-1:0]  EXP_RST  = 6'd31;
  localparam logic [DATA_W-1:0] SEED_RST = 32'd0;

  localparam logic [EXP_W-1:0] EXP_MIN      = 6'd3;
  localparam logic [EXP_W-1:0] EXP_MAX      = 6'd32;
  localparam logic [2:0]       MULT_RESIDUE = 3'd5;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_MOD  = 3'd1,
    STAT_BAD_MULT = 3'd2,
    STAT_BAD_INC  = 3'd3,
    STAT_BAD_SEED = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULT = 2'd0,
    REG_INC  = 2'd1,
    REG_EXP  = 2'd2,
    REG_SEED = 2'd3
  } cfg_reg_t;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SQA  = 9'b000000010,
    ST_SQD  = 9'b000000100,
    ST_MULS = 9'b000001000,
    ST_MULR = 9'b000010000,
    ST_MAGS = 9'b000100000,
    ST_DIVI = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;
    logic [DEN_W-1:0]  den;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

[rtl/lrr_in_if.sv]
// Request channel of the LCG range generator: valid/ready plus range bounds.
// Depends on lrr_pkg.
interface lrr_in_if;
  import lrr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] range_low;
  logic signed [DATA_W-1:0] range_high;

  modport source (output valid, output range_low, output range_high, input ready);
  modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

[rtl/lrr_out_if.sv]
// Result channel of the LCG range generator: valid/ready plus status and values.
// Depends on lrr_pkg.
interface lrr_out_if;
  import lrr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [DATA_W-1:0]        raw_value;
  logic signed [DATA_W-1:0] scaled_value;

  modport source (output valid, output status, output raw_value, output scaled_value,
                  input ready);
  modport sink   (input valid, input status, input raw_value, input scaled_value,
                  output ready);
endinterface

[rtl/lrr_mul.sv]
// Shared 32x32 multiplier with a registered 64-bit product.
// Depends on lrr_pkg.
module lrr_mul (
  input  logic                         clk,
  input  logic [lrr_pkg::DATA_W-1:0]   op_a,
  input  logic [lrr_pkg::DATA_W-1:0]   op_b,
  output logic [lrr_pkg::PROD_W-1:0]   prod
);
  import lrr_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;
endmodule

[rtl/lrr_div.sv]
// Restoring divider, one quotient bit per cycle; quotient must fit 32 bits.
// Depends on lrr_pkg (div_cmd_t, div_rsp_t).
module lrr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lrr_pkg::div_cmd_t cmd,
  output lrr_pkg::div_rsp_t rsp
);
  import lrr_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DATA_W-1:0] low_r, low_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign trial = {rem_r, low_r[DATA_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    den_nxt  = den_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, cmd.num[PROD_W-1:DATA_W]};
      low_nxt  = cmd.num[DATA_W-1:0];
      den_nxt  = cmd.den;
    end else if (busy_r) begin
      // shift in the next numerator bit, subtract when it fits
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_nxt = {low_r[DATA_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == QCNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = low_r;
endmodule

[rtl/lcg_random_with_range_unit.sv]
// LCG range generator top level: config registers, sequencer, result register.
// Depends on lrr_pkg, lrr_in_if, lrr_out_if, lrr_mul and lrr_div.
//
// Usage:
//   Configuration: write multiplier, increment, modulus exponent k and seed
//   through cfg_we/cfg_index/cfg_wdata while the block is idle. A seed write
//   also loads the generator state. Reset loads the classic constants
//   (a = 1103515245, c = 12345, k = 31) and a zero state.
//   Request channel in_req carries a signed range_low/range_high pair.
//   Result channel out_rsp returns status, the new state (raw_value) and
//   range_low + trunc((range_high - range_low) * (s + 1) / (2^k + 1)).
//   A failed configuration check returns a nonzero status, zero values and
//   leaves the state untouched.
// Timing:
//   One request at a time. From acceptance to out_rsp.valid a good draw makes
//   four passes through the one shared 32x32 multiplier (a*a, d*d, a*s,
//   |hi-lo|*s), then the divider kick, 32 steps of the one-bit-per-cycle
//   divider and the final load. A failed check goes to the final load after
//   the a*s pass. in_req.ready rises the cycle after the result is loaded.
//   The result sits in an output register; the next request is accepted while
//   it waits, and a finished draw holds in the last step until the receiver
//   takes the earlier result.
module lcg_random_with_range_unit #(
  parameter int STATE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lrr_pkg::DATA_W-1:0]    cfg_wdata,
  lrr_in_if.sink                        in_req,
  lrr_out_if.source                     out_rsp
);
  import lrr_pkg::*;

  // configuration and generator state
  logic [DATA_W-1:0] mult_r, mult_nxt;
  logic [DATA_W-1:0] inc_r, inc_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;
  logic [DATA_W-1:0] seed_r, seed_nxt;
  logic [DATA_W-1:0] cur_r, cur_nxt;

  // sequencer
  state_t state_r, state_nxt;

  // per-request working registers
  logic [DATA_W-1:0] lo_r, lo_nxt;
  logic [DATA_W-1:0] hi_r, hi_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] mag_r, mag_nxt;
  logic              aa_bad_r, aa_bad_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] scaled_r, scaled_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_raw_r, out_raw_nxt;
  logic [DATA_W-1:0] out_scaled_r, out_scaled_nxt;

  // datapath
  logic [DATA_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  div_cmd_t          div_cmd;
  div_rsp_t          div_rsp;

  logic [DEN_W-1:0]  m_w;
  logic [DATA_W-1:0] mask_w;
  logic [DATA_W-1:0] d_w;
  logic              exp_bad;
  logic              mult_pre_bad;
  logic              sq_le_m;
  logic              inc_bad;
  logic              seed_bad;
  logic [DATA_W:0]   diff_w;
  logic [DATA_W-1:0] step_s_w;

  lrr_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  lrr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .rsp   (div_rsp)
  );

  // modulus 2^k as a 33-bit value; meaningful only while k passes its check
  assign m_w    = DEN_W'(1) << exp_r;
  assign mask_w = DATA_W'(m_w - DEN_W'(1));
  assign d_w    = DATA_W'(m_w - {1'b0, mult_r});

  assign exp_bad      = (exp_r < EXP_MIN) || (exp_r > EXP_MAX) || (int'(exp_r) > STATE_BITS);
  assign mult_pre_bad = (mult_r[2:0] != MULT_RESIDUE) || ({1'b0, mult_r} >= m_w);
  // shared compare: product register against m (used for a*a and d*d)
  assign sq_le_m      = prod <= PROD_W'(m_w);
  assign inc_bad      = !inc_r[0];
  assign seed_bad     = {1'b0, seed_r} >= m_w;

  assign diff_w   = {hi_r[DATA_W-1], hi_r} - {lo_r[DATA_W-1], lo_r};
  assign step_s_w = (prod[DATA_W-1:0] + inc_r) & mask_w;

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_SQA: begin
        mul_a = mult_r;
        mul_b = mult_r;
      end
      ST_SQD: begin
        mul_a = d_w;
        mul_b = d_w;
      end
      ST_MULS: begin
        mul_a = mult_r;
        mul_b = cur_r;
      end
      ST_MAGS: begin
        mul_a = mag_r;
        mul_b = cur_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // kick the divider with |hi-lo| * (s+1) over m+1
  assign div_cmd.start = (state_r == ST_DIVI);
  assign div_cmd.num   = prod + PROD_W'(mag_r);
  assign div_cmd.den   = m_w + DEN_W'(1);

  assign in_req.ready = (state_r == ST_IDLE);

  always_comb begin
    mult_nxt       = mult_r;
    inc_nxt        = inc_r;
    exp_nxt        = exp_r;
    seed_nxt       = seed_r;
    cur_nxt        = cur_r;
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    aa_bad_nxt     = aa_bad_r;
    status_nxt     = status_r;
    scaled_nxt     = scaled_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_raw_nxt    = out_raw_r;
    out_scaled_nxt = out_scaled_r;

    // drop the result once the receiver takes it
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          lo_nxt    = in_req.range_low;
          hi_nxt    = in_req.range_high;
          state_nxt = ST_SQA;
        end
      end
      ST_SQA: begin
        neg_nxt   = diff_w[DATA_W];
        mag_nxt   = diff_w[DATA_W] ? DATA_W'(-diff_w) : DATA_W'(diff_w);
        state_nxt = ST_SQD;
      end
      ST_SQD: begin
        aa_bad_nxt = sq_le_m;
        state_nxt  = ST_MULS;
      end
      ST_MULS: begin
        // first failing check wins
        priority if (exp_bad) begin
          status_nxt = STAT_BAD_MOD;
        end else if (mult_pre_bad || aa_bad_r || sq_le_m) begin
          status_nxt = STAT_BAD_MULT;
        end else if (inc_bad) begin
          status_nxt = STAT_BAD_INC;
        end else if (seed_bad) begin
          status_nxt = STAT_BAD_SEED;
        end else begin
          status_nxt = STAT_OK;
        end
        if (status_nxt == STAT_OK) begin
          state_nxt = ST_MULR;
        end else begin
          scaled_nxt = '0;
          state_nxt  = ST_FIN;
        end
      end
      ST_MULR: begin
        // advance the generator state
        cur_nxt   = step_s_w;
        state_nxt = ST_MAGS;
      end
      ST_MAGS: begin
        state_nxt = ST_DIVI;
      end
      ST_DIVI: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          scaled_nxt = neg_r ? lo_r - div_rsp.quo : lo_r + div_rsp.quo;
          state_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_raw_nxt    = (status_r == STAT_OK) ? cur_r : '0;
          out_scaled_nxt = scaled_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MULT: mult_nxt = cfg_wdata;
        REG_INC:  inc_nxt  = cfg_wdata;
        REG_EXP:  exp_nxt  = cfg_wdata[EXP_W-1:0];
        REG_SEED: begin
          seed_nxt = cfg_wdata;
          cur_nxt  = cfg_wdata;
        end
        default: begin
          seed_nxt = seed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r      <= MULT_RST;
      inc_r       <= INC_RST;
      exp_r       <= EXP_RST;
      seed_r      <= SEED_RST;
      cur_r       <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      mult_r      <= mult_nxt;
      inc_r       <= inc_nxt;
      exp_r       <= exp_nxt;
      seed_r      <= seed_nxt;
      cur_r       <= cur_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    aa_bad_r     <= aa_bad_nxt;
    status_r     <= status_nxt;
    scaled_r     <= scaled_nxt;
    out_status_r <= out_status_nxt;
    out_raw_r    <= out_raw_nxt;
    out_scaled_r <= out_scaled_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.raw_value    = out_raw_r;
  assign out_rsp.scaled_value = out_scaled_r;

  // a failed check never leaks values
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_OK) |-> (out_raw_r == '0 && out_scaled_r == '0))
    else $error("failed check returned nonzero values");

  // the divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside its wait step");

  // an accepted request starts the check sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state_r == ST_SQA && !in_req.ready))
    else $error("accepted request did not start the sequence");
endmodule

[tb/tb_lcg_random_with_range_unit.sv]
// Self-checking testbench for lcg_random_with_range_unit: directed plan, then random phases.
// Predicts every draw in-house from a mirror of the config registers and the generator state.
// Depends on lrr_pkg, lrr_in_if, lrr_out_if and the block under test.
module tb_lcg_random_with_range_unit;
  import lrr_pkg::*;

  localparam int ITEM_GOAL   = 1820;   // directed rows plus about 1800 random requests
  localparam int CALM_TAIL   = 200;    // last requests run with no idling at all
  localparam int STALL_LIMIT = 1000;   // cycles with no handshake before giving up

  localparam logic signed [DATA_W-1:0] LO_END = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] HI_END = 32'sh7FFF_FFFF;

  typedef struct packed {
    status_t                  status;
    logic [DATA_W-1:0]        raw;
    logic signed [DATA_W-1:0] scaled;
  } draw_result_t;

  typedef enum logic { ROW_WRITE, ROW_DRAW } row_kind_t;

  // One row of the directed plan: either a register write or a request.
  // Rows with "known" set carry a hand-written result instead of a predicted one.
  typedef struct packed {
    row_kind_t                kind;
    cfg_reg_t                 idx;
    logic [DATA_W-1:0]        wdata;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic                     known;
    draw_result_t             want;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  lrr_in_if  req_if ();
  lrr_out_if rsp_if ();

  lcg_random_with_range_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_if),
    .out_rsp  (rsp_if)
  );

  // Mirror of the block's registers and generator state.
  logic [DATA_W-1:0] gen_mult;
  logic [DATA_W-1:0] gen_inc;
  logic [EXP_W-1:0]  gen_exp;
  logic [DATA_W-1:0] gen_seed;
  logic [DATA_W-1:0] gen_state;

  draw_result_t pending_draws[$];   // results owed by the block, oldest first
  int           mismatches = 0;
  int           drawn = 0;          // requests accepted so far
  int           idle_pct = 0;       // odds (percent) of starting an idle burst per slot
  int           dead_cycles = 0;

  // Configuration check, first failing rule wins.
  function automatic status_t settings_status(input logic [EXP_W-1:0] k,
                                              input logic [DATA_W-1:0] a, c, s);
    bit [63:0] m;
    bit [63:0] a64;
    bit [63:0] d;
    if (k < EXP_MIN || k > EXP_MAX) return STAT_BAD_MOD;
    m   = 64'd1 << k;
    a64 = 64'(a);
    if (a[2:0] != MULT_RESIDUE || a64 >= m) return STAT_BAD_MULT;
    if (a64 * a64 <= m) return STAT_BAD_MULT;
    d = m - a64;
    if (d * d <= m) return STAT_BAD_MULT;
    if (!c[0]) return STAT_BAD_INC;
    if (64'(s) >= m) return STAT_BAD_SEED;
    return STAT_OK;
  endfunction

  // Work out one draw and advance the mirrored state on success.
  function automatic draw_result_t predict_draw(input logic signed [DATA_W-1:0] lo, hi);
    draw_result_t r;
    bit [63:0]    m;
    bit [63:0]    s;
    bit [63:0]    mag;
    bit [63:0]    q;
    longint       diff;
    longint       sum;
    r.status = settings_status(gen_exp, gen_mult, gen_inc, gen_seed);
    r.raw    = '0;
    r.scaled = '0;
    if (r.status != STAT_OK) return r;
    m = 64'd1 << gen_exp;
    s = (64'(gen_mult) * 64'(gen_state) + 64'(gen_inc)) & (m - 64'd1);
    gen_state = s[DATA_W-1:0];
    // exact integer scaling, truncated toward zero on either side of lo
    diff = longint'(hi) - longint'(lo);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    q    = (mag * (s + 64'd1)) / (m + 64'd1);
    sum  = (diff < 0) ? longint'(lo) - longint'(q) : longint'(lo) + longint'(q);
    r.raw    = s[DATA_W-1:0];
    r.scaled = sum[DATA_W-1:0];
    return r;
  endfunction

  function automatic row_t write_row(input cfg_reg_t idx, input logic [DATA_W-1:0] data);
    row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.wdata = data;
    return r;
  endfunction

  function automatic row_t draw_row(input logic signed [DATA_W-1:0] lo, hi);
    row_t r;
    r      = '0;
    r.kind = ROW_DRAW;
    r.lo   = lo;
    r.hi   = hi;
    return r;
  endfunction

  function automatic row_t known_row(input logic signed [DATA_W-1:0] lo, hi,
                                     input status_t st, input logic [DATA_W-1:0] raw,
                                     input logic signed [DATA_W-1:0] scaled);
    row_t r;
    r             = draw_row(lo, hi);
    r.known       = 1'b1;
    r.want.status = st;
    r.want.raw    = raw;
    r.want.scaled = scaled;
    return r;
  endfunction

  // Drop valid and hold until every owed result has come back; the block is then idle.
  task automatic settle();
    @(negedge clk) req_if.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write one register and track it in the mirror. The caller lowers cfg_we afterwards.
  task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_MULT: gen_mult = data;
      REG_INC:  gen_inc  = data;
      REG_EXP:  gen_exp  = data[EXP_W-1:0];
      REG_SEED: begin
        gen_seed  = data;
        gen_state = data;
      end
    endcase
  endtask

  // Offer one request, optionally after an idle burst, and log its expected result
  // at the edge where it is accepted.
  task automatic push_draw(input logic signed [DATA_W-1:0] lo, hi,
                           input logic known, input draw_result_t typed);
    int           gap;
    draw_result_t r;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) gap = $urandom_range(1, 18);
    @(negedge clk);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.range_low  <= lo;
    req_if.range_high <= hi;
    do begin
      @(posedge clk);
    end while (!req_if.ready);
    r = predict_draw(lo, hi);
    pending_draws.push_back(known ? typed : r);
    drawn++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side backpressure: random stall bursts while idle_pct is nonzero.
  initial begin
    int stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        stall = $urandom_range(1, 18);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each returned result with the oldest expectation.
  always @(posedge clk) begin
    draw_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected result: status %0d raw %0h scaled %0d",
               rsp_if.status, rsp_if.raw_value, rsp_if.scaled_value);
        mismatches++;
      end else begin
        want = pending_draws.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.raw_value !== want.raw) begin
          $error("raw_value: expected %0h, got %0h", want.raw, rsp_if.raw_value);
          mismatches++;
        end
        if (rsp_if.scaled_value !== want.scaled) begin
          $error("scaled_value: expected %0d, got %0d", want.scaled, rsp_if.scaled_value);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
      dead_cycles = 0;
    else
      dead_cycles++;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    row_t                     plan[$];
    logic                     writing;
    logic [EXP_W-1:0]         k;
    bit [63:0]                m;
    logic [DATA_W-1:0]        a;
    logic [DATA_W-1:0]        c;
    logic [DATA_W-1:0]        s;
    logic                     broken;
    logic                     skip_seed;
    int                       first;
    int                       n;
    cfg_reg_t                 idx;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] ends [5];

    // Drive every input to a known value and hold reset.
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_MULT;
    cfg_wdata         = '0;
    req_if.valid      = 1'b0;
    req_if.range_low  = '0;
    req_if.range_high = '0;
    gen_mult  = MULT_RST;
    gen_inc   = INC_RST;
    gen_exp   = EXP_RST;
    gen_seed  = SEED_RST;
    gen_state = '0;
    ends      = '{LO_END, HI_END, 32'sd0, -32'sd1, 32'sd1};

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed plan. Defaults after reset give a first state of 12345 (seed zero).
    plan = {
      known_row(-5, -5, STAT_OK, 32'd12345, -5),
      draw_row(LO_END, HI_END),
      draw_row(HI_END, LO_END),                        // reversed range
      draw_row(0, 0),                                  // equal bounds
      write_row(REG_SEED, 32'h8000_0000),              // seed at the modulus
      known_row(1, 100, STAT_BAD_SEED, '0, '0),
      write_row(REG_EXP, 32'd32),                      // widest modulus, seed now fits
      draw_row(LO_END, LO_END),
      draw_row(-1, 0),
      write_row(REG_EXP, 32'hFFFF_FFC2),               // k = 2 after masking
      known_row(0, 10, STAT_BAD_MOD, '0, '0),
      write_row(REG_EXP, 32'h0000_0061),               // k = 33
      known_row(0, 10, STAT_BAD_MOD, '0, '0),
      write_row(REG_EXP, 32'hFFFF_FFFF),               // k = 63
      known_row(HI_END, LO_END, STAT_BAD_MOD, '0, '0),
      write_row(REG_EXP, 32'd3),                       // multiplier not below modulus
      known_row(0, 10, STAT_BAD_MULT, '0, '0),
      write_row(REG_MULT, 32'd5),
      write_row(REG_INC, 32'd2),                       // even increment
      known_row(0, 10, STAT_BAD_INC, '0, '0),
      write_row(REG_INC, 32'hFFFF_FFFF),
      write_row(REG_SEED, 32'd8),                      // seed equal to m = 8
      known_row(0, 10, STAT_BAD_SEED, '0, '0),
      write_row(REG_SEED, 32'd7),                      // smallest legal modulus
      draw_row(LO_END, HI_END),
      draw_row(100, -100),
      write_row(REG_EXP, 32'd31),
      write_row(REG_MULT, 32'd1103515246),             // wrong residue mod 8
      known_row(0, 10, STAT_BAD_MULT, '0, '0),
      write_row(REG_MULT, 32'd5),                      // a squared too small
      known_row(0, 10, STAT_BAD_MULT, '0, '0),
      write_row(REG_MULT, 32'h7FFF_FFFD),              // m - a squared too small
      known_row(0, 10, STAT_BAD_MULT, '0, '0),
      write_row(REG_MULT, MULT_RST),
      write_row(REG_INC, INC_RST),
      write_row(REG_EXP, 32'd32),
      write_row(REG_SEED, 32'd3),
      draw_row(-1000, 1000),                           // leaves a large state
      write_row(REG_EXP, 32'd4),                       // state now above the modulus
      write_row(REG_MULT, 32'd5),
      write_row(REG_INC, 32'd1),
      draw_row(HI_END, HI_END),
      draw_row(LO_END, HI_END)
    };

    idle_pct = 20;
    writing  = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!writing) settle();
        writing = 1'b1;
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        if (writing) begin
          @(negedge clk) cfg_we <= 1'b0;
          writing = 1'b0;
        end
        push_draw(plan[i].lo, plan[i].hi, plan[i].known, plan[i].want);
      end
    end

    // Random phases: mostly legal settings with random content, some broken ones.
    while (drawn < ITEM_GOAL) begin
      settle();

      case ($urandom_range(0, 9))
        0:       k = 6'd3;
        1:       k = 6'd4;
        2:       k = 6'd32;
        3:       k = 6'd31;
        default: k = 6'($urandom_range(5, 32));
      endcase
      m = 64'd1 << k;
      c = $urandom | 32'd1;
      s = $urandom & 32'(m - 64'd1);
      do begin
        a      = $urandom & 32'(m - 64'd1);
        a[2:0] = MULT_RESIDUE;
      end while (settings_status(k, a, c, s) != STAT_OK);

      broken = ($urandom_range(0, 4) == 0);
      if (broken) begin
        case ($urandom_range(0, 3))
          0: k = 6'($urandom_range(0, 63));
          1: a = $urandom;
          2: c[0] = 1'b0;
          default: s = $urandom;
        endcase
      end

      // Write in a rotated order; now and then keep the running state instead of reseeding.
      first     = $urandom_range(0, 3);
      skip_seed = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 4; i++) begin
        idx = cfg_reg_t'((first + i) % 4);
        case (idx)
          REG_MULT: write_reg(idx, a);
          REG_INC:  write_reg(idx, c);
          REG_EXP:  write_reg(idx, $urandom_range(0, 1) ? (($urandom & ~32'h3F) | 32'(k))
                                                        : 32'(k));
          REG_SEED: if (!skip_seed) write_reg(idx, s);
        endcase
      end
      @(negedge clk) cfg_we <= 1'b0;

      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 12;
        default: idle_pct = 40;
      endcase

      n = broken ? $urandom_range(2, 8) : $urandom_range(8, 60);
      repeat (n) begin
        if (drawn >= ITEM_GOAL - CALM_TAIL) idle_pct = 0;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            lo = $urandom;
            hi = $urandom;
          end
          4, 5: begin
            lo = $urandom;
            hi = lo + $urandom_range(0, 1000);
          end
          6: begin
            lo = $urandom;
            hi = lo;
          end
          7: begin
            lo = $urandom;
            hi = lo - $urandom_range(0, 1000);
          end
          default: begin
            lo = ends[$urandom_range(0, 4)];
            hi = ends[$urandom_range(0, 4)];
          end
        endcase
        push_draw(lo, hi, 1'b0, '0);
      end
    end

    // Drain, then give any stray result time to show up.
    settle();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_draws.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
